>>> rtl/core/rau_pkg.sv
// shared types, constants and codes for the rational arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int PW    = 2 * WIDTH;          // cross product width
    localparam int CW    = $clog2(PW + 1);     // step counter width

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_CMP = 3'd4
    } mode_t;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [WIDTH-1:0] a_num;
        logic [WIDTH-2:0]        a_den;
        logic signed [WIDTH-1:0] b_num;
        logic [WIDTH-2:0]        b_den;
    } rau_req_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] res_num;
        logic [WIDTH-2:0]        res_den;
        logic [1:0]              order;
        logic [1:0]              status;
    } rau_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_COMB,
        S_GSHIFT,
        S_GODD,
        S_GLOOP,
        S_GSCALE,
        S_DIVN,
        S_DIVD,
        S_PACK,
        S_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul0;
        logic mul1;
        logic comb;
        logic gshift;
        logic godd;
        logic gloop;
        logic gscale;
        logic div_init;
        logic div_step;
        logic div_num_done;
        logic pack;
    } rau_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic early;       // result decided without arithmetic
        logic cmp_mode;
        logic gcd_trivial; // one operand zero
        logic both_even;
        logic a_even;
        logic b_zero;
        logic scale_done;
        logic div_last;
    } rau_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/rau_ctrl.sv
// controller state machine sequencing products, gcd and quotients
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire rau_pkg::rau_sts_t sts,
    output rau_pkg::rau_cmd_t      cmd
);
    import rau_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state, early flag is valid once the first product cycle is done
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_MUL0;
            S_MUL0:   state_next = S_MUL1;
            S_MUL1:   state_next = sts.early ? S_OUT : S_COMB;
            S_COMB:   state_next = sts.cmp_mode ? S_OUT : S_GSHIFT;
            S_GSHIFT:
            begin
                if (sts.gcd_trivial)     state_next = S_DIVN;
                else if (!sts.both_even) state_next = S_GODD;
            end
            S_GODD:   if (!sts.a_even) state_next = S_GLOOP;
            S_GLOOP:  if (sts.b_zero) state_next = S_GSCALE;
            S_GSCALE: if (sts.scale_done) state_next = S_DIVN;
            S_DIVN:   if (sts.div_last) state_next = S_DIVD;
            S_DIVD:   if (sts.div_last) state_next = S_PACK;
            S_PACK:   state_next = S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_MUL0:   cmd.mul0 = 1'b1;
            S_MUL1:   cmd.mul1 = 1'b1;
            S_COMB:   cmd.comb = 1'b1;
            S_GSHIFT:
            begin
                cmd.gshift   = 1'b1;
                cmd.div_init = sts.gcd_trivial;
            end
            S_GODD:   cmd.godd = 1'b1;
            S_GLOOP:  cmd.gloop = 1'b1;
            S_GSCALE:
            begin
                cmd.gscale   = 1'b1;
                cmd.div_init = sts.scale_done;
            end
            S_DIVN:
            begin
                cmd.div_step     = 1'b1;
                cmd.div_num_done = sts.div_last;
            end
            S_DIVD:   cmd.div_step = 1'b1;
            S_PACK:   cmd.pack = 1'b1;
            S_OUT:    out_valid = 1'b1;
            default:  cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    // accept only while idle
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> state_reg == S_IDLE)
        else $error("request accepted outside idle");
    // a shown result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before taken");
    // never both sides open
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready and valid together");
`endif
endmodule
`default_nettype wire

>>> rtl/core/rau_dp.sv
// datapath: cross products, binary gcd, restoring division, range check
`timescale 1ns / 1ps
`default_nettype none
module rau_dp (
    input  wire logic              clk,
    input  wire rau_pkg::rau_req_t req,
    input  wire rau_pkg::rau_cmd_t cmd,
    output rau_pkg::rau_sts_t      sts,
    output rau_pkg::rau_rsp_t      rsp
);
    import rau_pkg::*;

    localparam int MW = WIDTH;          // magnitude width
    localparam logic [CW-1:0] LAST = CW'(PW - 1);

    // operand registers
    logic [2:0]    mode_reg;
    logic          an_reg, bn_reg;
    logic [MW-1:0] am_reg, bm_reg;
    logic [MW-1:0] ad_reg, bd_reg;
    // products
    logic [PW-1:0] p1_reg, p2_reg, p3_reg;
    // gcd working values and result magnitude / denominator
    logic [PW-1:0] rm_reg, rd_reg, ga_reg, gb_reg;
    logic          rn_reg;
    logic [CW-1:0] k_reg;
    // divider
    logic [PW-1:0] dq_reg, dr_reg, qn_reg;
    logic [CW-1:0] cnt_reg;
    logic          early_reg;
    rau_rsp_t      rsp_reg;

    logic [MW-1:0] an_mag, bn_mag;
    logic [PW:0]   trial;
    logic [PW-1:0] rshift, ga_sw, gb_sw, gb_odd;
    logic          cmp_ge, sum_neg;
    logic [PW-1:0] sum_mag;
    logic          tn;
    logic [MW-1:0] lim;

    assign an_mag = req.a_num[WIDTH-1] ? MW'(-req.a_num) : MW'(req.a_num);
    assign bn_mag = req.b_num[WIDTH-1] ? MW'(-req.b_num) : MW'(req.b_num);
    assign lim    = {1'b1, {(MW-1){1'b0}}};

    // signed sum of the two cross products
    assign tn = (mode_reg == MODE_ADD) ? bn_reg : (bm_reg != '0 && !bn_reg);
    always_comb
    begin
        cmp_ge = p1_reg >= p2_reg;
        if (an_reg == tn)
        begin
            sum_mag = p1_reg + p2_reg;
            sum_neg = an_reg;
        end
        else if (cmp_ge)
        begin
            sum_mag = p1_reg - p2_reg;
            sum_neg = an_reg;
        end
        else
        begin
            sum_mag = p2_reg - p1_reg;
            sum_neg = tn;
        end
        if (sum_mag == '0)
            sum_neg = 1'b0;
    end

    // gcd subtract step, b made odd first
    assign gb_odd = gb_reg[0] ? gb_reg : (gb_reg >> 1);
    always_comb
    begin
        if (ga_reg > gb_reg)
        begin
            ga_sw = gb_reg;
            gb_sw = ga_reg - gb_reg;
        end
        else
        begin
            ga_sw = ga_reg;
            gb_sw = gb_reg - ga_reg;
        end
    end

    // divider remainder step
    assign rshift = {dr_reg[PW-2:0], dq_reg[PW-1]};
    assign trial  = {dr_reg[PW-1], rshift} - {1'b0, ga_reg};

    assign sts.early       = early_reg;
    assign sts.cmp_mode    = mode_reg == MODE_CMP;
    assign sts.gcd_trivial = rm_reg == '0 || rd_reg == '0;
    assign sts.both_even   = !ga_reg[0] && !gb_reg[0];
    assign sts.a_even      = !ga_reg[0];
    assign sts.b_zero      = gb_reg == '0;
    assign sts.scale_done  = k_reg == '0;
    assign sts.div_last    = cnt_reg == LAST;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= req.mode;
            an_reg   <= req.a_num[WIDTH-1];
            bn_reg   <= req.b_num[WIDTH-1];
            am_reg   <= an_mag;
            bm_reg   <= bn_mag;
            ad_reg   <= MW'(req.a_den);
            bd_reg   <= MW'(req.b_den);
            k_reg    <= '0;
        end
        if (cmd.mul0)
        begin
            early_reg <= 1'b1;
            rsp_reg   <= '0;
            if (mode_reg > 3'(MODE_CMP))
                rsp_reg <= '0;
            else if (ad_reg == '0 || bd_reg == '0 ||
                     (mode_reg == MODE_DIV && bm_reg == '0))
                rsp_reg.status <= ST_DIVZERO;
            else
                early_reg <= 1'b0;
            if (am_reg == '0) an_reg <= 1'b0;
            if (bm_reg == '0) bn_reg <= 1'b0;
            // first product
            if (mode_reg == MODE_MUL)
                p1_reg <= am_reg * bm_reg;
            else
                p1_reg <= am_reg * bd_reg;
        end
        if (cmd.mul1)
        begin
            if (mode_reg == MODE_DIV)
                p2_reg <= ad_reg * bm_reg;
            else
                p2_reg <= ad_reg * bm_reg;
            p3_reg <= ad_reg * bd_reg;
        end
        if (cmd.comb)
        begin
            ga_reg <= '0;
            case (mode_reg)
                MODE_ADD, MODE_SUB, MODE_CMP:
                begin
                    rm_reg <= sum_mag;
                    rd_reg <= p3_reg;
                    rn_reg <= sum_neg;
                    ga_reg <= sum_mag;
                    gb_reg <= p3_reg;
                    rsp_reg <= '0;
                    rsp_reg.order <= (sum_mag == '0) ? ORD_EQUAL :
                                     (sum_neg ? ORD_LESS : ORD_GREATER);
                end
                MODE_MUL:
                begin
                    rm_reg <= p1_reg;
                    rd_reg <= p3_reg;
                    rn_reg <= (an_reg != bn_reg) && p1_reg != '0;
                    ga_reg <= p1_reg;
                    gb_reg <= p3_reg;
                end
                default:
                begin
                    rm_reg <= p1_reg;
                    rd_reg <= p2_reg;
                    rn_reg <= (an_reg != bn_reg) && p1_reg != '0;
                    ga_reg <= p1_reg;
                    gb_reg <= p2_reg;
                end
            endcase
        end
        if (cmd.gshift)
        begin
            if (rm_reg == '0)
                ga_reg <= rd_reg;
            else if (rd_reg == '0)
                ga_reg <= rm_reg;
            else if (sts.both_even)
            begin
                ga_reg <= ga_reg >> 1;
                gb_reg <= gb_reg >> 1;
                k_reg  <= k_reg + 1'b1;
            end
        end
        if (cmd.godd && !ga_reg[0])
            ga_reg <= ga_reg >> 1;
        if (cmd.gloop && gb_reg != '0)
        begin
            // halve b while even, otherwise one subtract step
            if (!gb_reg[0])
                gb_reg <= gb_odd;
            else
            begin
                ga_reg <= ga_sw;
                gb_reg <= gb_sw;
            end
        end
        if (cmd.gscale && k_reg != '0)
        begin
            ga_reg <= ga_reg << 1;
            k_reg  <= k_reg - 1'b1;
        end
        if (cmd.div_init)
        begin
            dq_reg  <= rm_reg;
            dr_reg  <= '0;
            cnt_reg <= '0;
        end
        // one quotient bit a cycle, quotient shifts into dq
        if (cmd.div_step)
        begin
            if (!trial[PW])
            begin
                dr_reg <= trial[PW-1:0];
                dq_reg <= {dq_reg[PW-2:0], 1'b1};
            end
            else
            begin
                dr_reg <= rshift;
                dq_reg <= {dq_reg[PW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
            if (cmd.div_num_done)
            begin
                qn_reg  <= {dq_reg[PW-2:0], !trial[PW]};
                dq_reg  <= rd_reg;
                dr_reg  <= '0;
                cnt_reg <= '0;
            end
        end
        if (cmd.pack)
        begin
            rsp_reg <= '0;
            if (qn_reg[PW-1:MW] != '0 || dq_reg[PW-1:MW-1] != '0 ||
                qn_reg[MW-1:0] > (rn_reg ? lim : lim - 1'b1))
                rsp_reg.status <= ST_OVERFLOW;
            else
            begin
                rsp_reg.res_num <= rn_reg ? -qn_reg[MW-1:0] : qn_reg[MW-1:0];
                rsp_reg.res_den <= dq_reg[MW-2:0];
            end
        end
    end

    assign rsp = rsp_reg;

`ifndef ASSERT_OFF
    // gcd loop keeps a odd
    a_godd: assert property (@(posedge clk)
        cmd.gloop |-> ga_reg[0])
        else $error("gcd operand lost odd form");
    // division count stays in range
    a_cnt: assert property (@(posedge clk)
        cmd.div_step |-> cnt_reg <= LAST)
        else $error("divider step count out of range");
    // a nonzero divisor for the quotient
    a_div: assert property (@(posedge clk)
        cmd.div_step |-> ga_reg != '0)
        else $error("division by zero gcd");
`endif
endmodule
`default_nettype wire

>>> rtl/core/rational_arithmetic_unit_core.sv
// top level of the rational arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
// Exact add, subtract, multiply, divide and compare of two fractions. One
// request is worked at a time: 32x32 cross products, a binary gcd over the
// 64-bit intermediates (one shift or subtract per cycle), then two restoring
// divisions that reduce numerator and denominator. Compare and error cases
// finish without the gcd and the divisions. The result register holds until
// taken; no new request is accepted until then.
module rational_arithmetic_unit_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rau_pkg::rau_req_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rau_pkg::rau_rsp_t      out_data
);
    import rau_pkg::*;

    rau_cmd_t cmd;
    rau_sts_t sts;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rau_dp u_dp (
        .clk (clk),
        .req (in_data),
        .cmd (cmd),
        .sts (sts),
        .rsp (out_data)
    );
endmodule
`default_nettype wire
